FILE: hdl/ihc_pkg.sv
// Shared types and constants for the IPv4 probe header classifier.
// No dependencies; imported by every module in hdl/.
package ihc_pkg;

    localparam int LENGTH_BITS_DEF = 16;

    localparam logic [15:0] ETH_TYPE_IPV4   = 16'h0800;
    localparam logic [15:0] ETH_TYPE_VLAN   = 16'h8100;
    localparam logic [15:0] ETH_TYPE_QINQ   = 16'h88A8;

    localparam logic [15:0] MORE_FRAGMENTS  = 16'h2000;
    localparam logic [15:0] OFFSET_MASK     = 16'h1FFF;

    localparam logic [7:0]  IP_PROTO_TCP    = 8'd6;
    localparam logic [7:0]  IP_PROTO_UDP    = 8'd17;

    localparam logic [3:0]  IP_VERSION_4    = 4'd4;
    localparam logic [3:0]  IHL_MIN         = 4'd5;

    localparam logic [7:0]  TCP_FIN         = 8'h01;
    localparam logic [7:0]  TCP_SYN         = 8'h02;
    localparam logic [7:0]  TCP_RST         = 8'h04;
    localparam logic [7:0]  TCP_ACK         = 8'h10;

    typedef enum logic [2:0] {
        CLS_TRUNCATED   = 3'd0,
        CLS_UNSUPPORTED = 3'd1,
        CLS_FRAGMENT    = 3'd2,
        CLS_TCP_PROBE   = 3'd3,
        CLS_UDP_PROBE   = 3'd4,
        CLS_BAD_SYN     = 3'd5,
        CLS_OTHER_IPV4  = 3'd6
    } frame_class_t;

    // Header fields captured so far in the current frame.
    typedef struct packed {
        logic [15:0] ether_type;
        logic        tag_seen;
        logic [7:0]  ver_ihl;
        logic [15:0] tot_len;
        logic [15:0] frag_word;
        logic [7:0]  protocol;
        logic [31:0] src_word;
        logic [15:0] port_word;
        logic [7:0]  tcp_flags;
        logic [15:0] udp_len;
    } hdr_state_t;

    // One classification result.
    typedef struct packed {
        frame_class_t cls;
        logic         ipv4_valid;
        logic [31:0]  src_addr;
        logic [7:0]   proto;
        logic [15:0]  dst_port;
    } result_t;

    function automatic logic is_tag_type(input logic [15:0] t);
        return (t == ETH_TYPE_VLAN) || (t == ETH_TYPE_QINQ);
    endfunction

endpackage

FILE: hdl/ihc_capture.sv
// Byte counter and header field capture registers.
// Depends on ihc_pkg.
module ihc_capture
    import ihc_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   step,
    input  logic [7:0]             data_byte,
    input  logic                   data_last,
    output hdr_state_t             cap,
    output logic [LENGTH_BITS-1:0] len
);

    localparam logic [LENGTH_BITS-1:0] POS_MAX = '1;

    hdr_state_t             st_reg, st_next;
    logic [LENGTH_BITS-1:0] pos_reg, pos_next;
    logic [LENGTH_BITS-1:0] l3, r, s, hdr;
    logic [15:0]            et_shift;
    logic                   et_hit;

    assign l3       = st_reg.tag_seen ? LENGTH_BITS'(18) : LENGTH_BITS'(14);
    assign r        = pos_reg - l3;
    assign hdr      = LENGTH_BITS'({st_reg.ver_ihl[3:0], 2'b00});
    assign s        = r - hdr;
    assign et_shift = {st_reg.ether_type[7:0], data_byte};
    assign et_hit   = (pos_reg == LENGTH_BITS'(12)) || (pos_reg == LENGTH_BITS'(13)) ||
                      (st_reg.tag_seen && ((pos_reg == LENGTH_BITS'(16)) ||
                                           (pos_reg == LENGTH_BITS'(17))));

    // saturating byte count
    assign len = (pos_reg == POS_MAX) ? pos_reg : pos_reg + LENGTH_BITS'(1);

    // fields after taking in the current byte
    always_comb begin
        cap = st_reg;
        if (et_hit) begin
            cap.ether_type = et_shift;
            if (pos_reg == LENGTH_BITS'(13)) begin
                cap.tag_seen = is_tag_type(et_shift);
            end
        end else if (pos_reg >= l3) begin
            if (r == LENGTH_BITS'(0)) begin
                cap.ver_ihl = data_byte;
            end else if (r == LENGTH_BITS'(2) || r == LENGTH_BITS'(3)) begin
                cap.tot_len = {st_reg.tot_len[7:0], data_byte};
            end else if (r == LENGTH_BITS'(6) || r == LENGTH_BITS'(7)) begin
                cap.frag_word = {st_reg.frag_word[7:0], data_byte};
            end else if (r == LENGTH_BITS'(9)) begin
                cap.protocol = data_byte;
            end else if (r >= LENGTH_BITS'(12) && r <= LENGTH_BITS'(15)) begin
                cap.src_word = {st_reg.src_word[23:0], data_byte};
            end
            // transport header, offset by the IPv4 header length
            if (r != LENGTH_BITS'(0) && st_reg.ver_ihl[3:0] >= IHL_MIN && r >= hdr) begin
                if (s == LENGTH_BITS'(2) || s == LENGTH_BITS'(3)) begin
                    cap.port_word = {st_reg.port_word[7:0], data_byte};
                end else if (s == LENGTH_BITS'(4) || s == LENGTH_BITS'(5)) begin
                    cap.udp_len = {st_reg.udp_len[7:0], data_byte};
                end else if (s == LENGTH_BITS'(13)) begin
                    cap.tcp_flags = data_byte;
                end
            end
        end
    end

    always_comb begin
        st_next  = st_reg;
        pos_next = pos_reg;
        if (step) begin
            if (data_last) begin
                st_next  = '0;
                pos_next = '0;
            end else begin
                st_next  = cap;
                pos_next = len;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg  <= '0;
            pos_reg <= '0;
        end else begin
            st_reg  <= st_next;
            pos_reg <= pos_next;
        end
    end

endmodule

FILE: hdl/ihc_classify.sv
// End-of-frame decision logic over the captured header fields.
// Depends on ihc_pkg.
module ihc_classify
    import ihc_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  hdr_state_t             cap,
    input  logic [LENGTH_BITS-1:0] len,
    output result_t                res
);

    // wide enough for the frame length and for a 16-bit field plus offset
    localparam int CW = ((LENGTH_BITS > 16) ? LENGTH_BITS : 16) + 1;

    logic [CW-1:0] len_w, l3, hdr, l4;
    logic [3:0]    ihl;
    logic          short_eth, inner_tag, not_ipv4, hdr_bad, frag;
    logic          fin, syn, rst, ack, tcp_short, udp_bad;

    assign ihl   = cap.ver_ihl[3:0];
    assign len_w = CW'(len);
    assign l3    = cap.tag_seen ? CW'(18) : CW'(14);
    assign hdr   = CW'({ihl, 2'b00});
    assign l4    = l3 + hdr;

    assign short_eth = (len_w < CW'(14)) || (cap.tag_seen && len_w < CW'(18));
    assign inner_tag = cap.tag_seen && is_tag_type(cap.ether_type);
    assign not_ipv4  = cap.ether_type != ETH_TYPE_IPV4;
    assign hdr_bad   = (len_w < l3 + CW'(20)) || (cap.ver_ihl[7:4] != IP_VERSION_4) ||
                       (ihl < IHL_MIN) || (len_w < l4) || (CW'(cap.tot_len) < hdr) ||
                       (CW'(cap.tot_len) + l3 > len_w);
    assign frag      = (cap.frag_word & (MORE_FRAGMENTS | OFFSET_MASK)) != 16'd0;

    assign fin = (cap.tcp_flags & TCP_FIN) != 8'd0;
    assign syn = (cap.tcp_flags & TCP_SYN) != 8'd0;
    assign rst = (cap.tcp_flags & TCP_RST) != 8'd0;
    assign ack = (cap.tcp_flags & TCP_ACK) != 8'd0;

    assign tcp_short = len_w < l4 + CW'(20);
    assign udp_bad   = (len_w < l4 + CW'(8)) || (cap.udp_len < 16'd8) ||
                       (CW'(cap.udp_len) + l4 > len_w);

    always_comb begin
        res = '{cls: CLS_TRUNCATED, ipv4_valid: 1'b0, src_addr: 32'd0,
                proto: 8'd0, dst_port: 16'd0};
        if (short_eth) begin
            res.cls = CLS_TRUNCATED;
        end else if (inner_tag || not_ipv4) begin
            res.cls = CLS_UNSUPPORTED;
        end else if (hdr_bad) begin
            res.cls = CLS_TRUNCATED;
        end else begin
            res.ipv4_valid = 1'b1;
            res.src_addr   = cap.src_word;
            if (frag) begin
                res.cls = CLS_FRAGMENT;
            end else if (cap.protocol == IP_PROTO_TCP) begin
                if (tcp_short) begin
                    res.cls = CLS_TRUNCATED;
                end else if (syn && (fin || rst)) begin
                    res.cls = CLS_BAD_SYN;
                end else if (syn && !ack) begin
                    res.cls      = CLS_TCP_PROBE;
                    res.proto    = IP_PROTO_TCP;
                    res.dst_port = cap.port_word;
                end else begin
                    res.cls = CLS_OTHER_IPV4;
                end
            end else if (cap.protocol == IP_PROTO_UDP) begin
                if (udp_bad) begin
                    res.cls = CLS_TRUNCATED;
                end else begin
                    res.cls      = CLS_UDP_PROBE;
                    res.proto    = IP_PROTO_UDP;
                    res.dst_port = cap.port_word;
                end
            end else begin
                res.cls = CLS_OTHER_IPV4;
            end
        end
    end

endmodule

FILE: hdl/ipv4_probe_header_classifier_unit.sv
// Top level of the IPv4 probe header classifier.
// Depends on ihc_pkg, ihc_capture and ihc_classify.
//
// Usage:
//   s_ channel: one frame byte per item (s_frame_byte), s_frame_last marks the
//   final byte. Bytes of back-to-back frames may stream without gaps.
//   m_ channel: one result item per frame, issued for the last byte: class,
//   ipv4_valid, source address, protocol and destination port.
// Timing:
//   One byte per cycle sustained while no last byte waits on a pending result.
//   A byte goes into the input register when accepted and is counted/captured
//   at the edge that takes it out of that register; for a last byte the
//   classification is loaded into the result register at that same edge, raising m_valid.
//   The capture and classification logic sits between these two registers.
// Stall:
//   While a result waits on m_ready, non-last bytes still flow; a last byte
//   holds in the input register until the result register frees up, and
//   s_ready drops only then.
// Reset:
//   aresetn (sync, active low) empties both registers and clears the byte
//   count and all captured fields; the next byte starts a new frame.
module ipv4_probe_header_classifier_unit
    import ihc_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_frame_byte,
    input  logic        s_frame_last,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_frame_class,
    output logic        m_ipv4_valid,
    output logic [31:0] m_source_address,
    output logic [7:0]  m_transport_protocol,
    output logic [15:0] m_dst_port
);

    // input register
    logic       in_vld_reg, in_vld_next;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    // result register
    logic       m_valid_reg, m_valid_next;
    result_t    res_reg;
    result_t    res_next;

    hdr_state_t             cap;
    logic [LENGTH_BITS-1:0] len;
    logic                   out_free, proc, s_acc;

    assign out_free = !m_valid_reg || m_ready;
    // a non-last byte never needs the result register
    assign proc     = in_vld_reg && (!in_last_reg || out_free);
    assign s_ready  = !in_vld_reg || proc;
    assign s_acc    = s_valid && s_ready;

    ihc_capture #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_capture (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (proc),
        .data_byte (in_byte_reg),
        .data_last (in_last_reg),
        .cap       (cap),
        .len       (len)
    );

    ihc_classify #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_classify (
        .cap (cap),
        .len (len),
        .res (res_next)
    );

    always_comb begin
        in_vld_next = in_vld_reg;
        if (s_acc) begin
            in_vld_next = 1'b1;
        end else if (proc) begin
            in_vld_next = 1'b0;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (proc && in_last_reg) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            in_vld_reg  <= in_vld_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            in_byte_reg <= s_frame_byte;
            in_last_reg <= s_frame_last;
        end
        if (proc && in_last_reg) begin
            res_reg <= res_next;
        end
    end

    assign m_valid              = m_valid_reg;
    assign m_frame_class        = res_reg.cls;
    assign m_ipv4_valid         = res_reg.ipv4_valid;
    assign m_source_address     = res_reg.src_addr;
    assign m_transport_protocol = res_reg.proto;
    assign m_dst_port           = res_reg.dst_port;

`ifndef SYNTHESIS
    // a finished frame always lands in the result register
    a_last_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        proc && in_last_reg |=> m_valid_reg)
        else $error("last byte processed without a result");

    // a last byte is never processed over a pending, untaken result
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        proc && in_last_reg |-> !m_valid_reg || m_ready)
        else $error("result overwritten");

    a_src_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !res_reg.ipv4_valid |-> res_reg.src_addr == 32'd0)
        else $error("source address without valid IPv4 header");

    a_probe_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && (res_reg.proto != 8'd0 || res_reg.dst_port != 16'd0) |->
        (res_reg.cls == CLS_TCP_PROBE && res_reg.proto == IP_PROTO_TCP) ||
        (res_reg.cls == CLS_UDP_PROBE && res_reg.proto == IP_PROTO_UDP))
        else $error("protocol or port outside a probe result");

    a_probe_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && (res_reg.cls == CLS_TCP_PROBE || res_reg.cls == CLS_UDP_PROBE ||
                        res_reg.cls == CLS_FRAGMENT) |-> res_reg.ipv4_valid)
        else $error("IPv4 class without ipv4_valid");
`endif

endmodule
